/* src/bit_packer_msb_first_defines.svh */
// assertion macros for the packer modules (used by bpm_back)
`ifndef BIT_PACKER_MSB_FIRST_DEFINES_SVH
`define BIT_PACKER_MSB_FIRST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bit packer check failed");

// next-cycle implication, checked outside reset
`define BPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bit packer check failed");

`endif

/* src/bpm_pkg.sv */
package bpm_pkg;

   localparam int MAX_CODE_BITS_DEF = 64;
   localparam int VALUE_W           = 64;
   localparam int LENGTH_W          = 7;
   localparam int BYTE_W            = 8;
   localparam int PEND_W            = 7;
   localparam int CNT_W             = 3;
   localparam int QUEUE_DEPTH       = 4;

   typedef enum logic [0:0] {
      OP_APPEND = 1'b0,
      OP_FLUSH  = 1'b1
   } bpm_op_type;

endpackage

/* src/bpm_if.sv */
interface bpm_req_if;
   import bpm_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [VALUE_W-1:0]  code_value;
   logic [LENGTH_W-1:0] code_length;

   modport source (output valid, output operation, output code_value, output code_length,
                   input ready);
   modport sink (input valid, input operation, input code_value, input code_length,
                 output ready);
endinterface

interface bpm_rsp_if;
   import bpm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

/* src/bpm_front.sv */
module bpm_front #(
   parameter int MAX_CODE_BITS = bpm_pkg::MAX_CODE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   bpm_req_if.sink req,
   output logic push_valid,
   input  logic push_ready,
   output logic [8*((MAX_CODE_BITS+7)/8)-1:0] push_word,
   output logic [$clog2((MAX_CODE_BITS+7)/8+1)-1:0] push_count
);
   import bpm_pkg::*;

   localparam int MAX_BYTES = (MAX_CODE_BITS + 7) / 8;
   localparam int WB  = 8 * MAX_BYTES;
   localparam int NBW = $clog2(MAX_BYTES + 1);
   localparam int CW  = MAX_CODE_BITS + PEND_W;
   localparam int LW  = $clog2(MAX_CODE_BITS + 1);
   localparam int TW  = $clog2(CW + 1);

   logic [PEND_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              is_flush;
   logic [LW-1:0]     len_eff;
   logic [CW-1:0]     masked;
   logic [CW-1:0]     comb_bits;
   logic [TW-1:0]     total;
   logic [CNT_W-1:0]  rem;
   logic [CW-1:0]     aligned;
   logic              accept;

   always_comb begin
      is_flush = (req.operation == OP_FLUSH);
      if (is_flush) begin
         len_eff = '0;
      end else if (req.code_length > LENGTH_W'(MAX_CODE_BITS)) begin
         len_eff = LW'(MAX_CODE_BITS);
      end else begin
         len_eff = req.code_length[LW-1:0];
      end
      masked    = CW'(req.code_value[MAX_CODE_BITS-1:0] &
                      ~({MAX_CODE_BITS{1'b1}} << len_eff));
      comb_bits = (CW'(acc_ff) << len_eff) | masked;
      total     = TW'(cnt_ff) + TW'(len_eff);
      rem       = total[CNT_W-1:0];
      aligned   = comb_bits << (TW'(CW) - total);
      push_word = aligned[CW-1 -: WB];
      if (is_flush) begin
         push_count = (cnt_ff != '0) ? NBW'(1) : '0;
         acc_in     = '0;
         cnt_in     = '0;
      end else begin
         push_count = NBW'(total >> 3);
         acc_in     = comb_bits[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
         cnt_in     = rem;
      end
   end

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = req.valid && (push_count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/bpm_queue.sv */
module bpm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bpm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/bpm_back.sv */
`include "bit_packer_msb_first_defines.svh"

module bpm_back #(
   parameter int MAX_CODE_BITS = bpm_pkg::MAX_CODE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [8*((MAX_CODE_BITS+7)/8)-1:0] pop_word,
   input  logic [$clog2((MAX_CODE_BITS+7)/8+1)-1:0] pop_count,
   bpm_rsp_if.source rsp
);
   import bpm_pkg::*;

   localparam int MAX_BYTES = (MAX_CODE_BITS + 7) / 8;
   localparam int WB  = 8 * MAX_BYTES;
   localparam int NBW = $clog2(MAX_BYTES + 1);

   logic [WB-1:0]  word_ff, word_in;
   logic [NBW-1:0] left_ff, left_in;
   logic           rsp_fire, pop_fire;

   assign rsp.valid    = (left_ff != '0);
   assign rsp.last     = (left_ff == NBW'(1));
   assign rsp.out_byte = word_ff[WB-1 -: BYTE_W];
   assign rsp_fire     = rsp.valid && rsp.ready;
   assign pop_ready    = (left_ff == '0) || (rsp.last && rsp.ready);
   assign pop_fire     = pop_valid && pop_ready;

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      if (pop_fire) begin
         word_in = pop_word;
         left_in = pop_count;
      end else if (rsp_fire) begin
         word_in = word_ff << BYTE_W;
         left_in = left_ff - NBW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   `BPM_ASSERT_NOW(a_left_range, 1'b1, left_ff <= NBW'(MAX_BYTES))
   `BPM_ASSERT_NEXT(a_loaded_nonempty, pop_fire, left_ff != '0)
   `BPM_ASSERT_NEXT(a_drain_empty, rsp_fire && rsp.last && !pop_valid, left_ff == '0)

endmodule

/* src/bit_packer_msb_first.sv */
// msb-first variable-length bit packer
// req channel: one request per handshake, operation append or flush;
//   append takes the low code_length bits of code_value (length saturates
//   at MAX_CODE_BITS), flush pads the pending partial byte with zeros
// rsp channel: one byte per handshake, earliest bit in bit 7; last marks
//   the final byte caused by a request; requests that make no byte give none
// throughput: one request per cycle while the request queue has room; the
//   byte side moves one byte per cycle while rsp.ready is high, so a
//   multi-byte request holds the output until its last byte and the
//   four-entry queue absorbs the bursts; an accepted request is written
//   into the queue and then loaded into the output stage, which offers its first byte
// a stalled rsp.ready holds the current byte; the queue fills and then
//   req.ready drops until a slot frees
// reset clears the pending bits, the queue and the output stage
module bit_packer_msb_first #(
   parameter int MAX_CODE_BITS = bpm_pkg::MAX_CODE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   bpm_req_if.sink   req_chan,
   bpm_rsp_if.source rsp_chan
);
   import bpm_pkg::*;

   localparam int MAX_BYTES = (MAX_CODE_BITS + 7) / 8;
   localparam int WB  = 8 * MAX_BYTES;
   localparam int NBW = $clog2(MAX_BYTES + 1);
   localparam int EW  = WB + NBW;

   logic           push_valid, push_ready;
   logic [WB-1:0]  push_word;
   logic [NBW-1:0] push_count;
   logic           pop_valid, pop_ready;
   logic [EW-1:0]  pop_data;

   bpm_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .push_count (push_count)
   );

   bpm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_word, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bpm_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_data[EW-1 -: WB]),
      .pop_count (pop_data[NBW-1:0]),
      .rsp       (rsp_chan)
   );

endmodule
